// ===== rtl/upd_pkg.sv =====
package upd_pkg;

	localparam int QDepth = 4;
	localparam int QPtrW = $clog2(QDepth);
	localparam int QCntW = QPtrW + 1;
	localparam int MaxRes = 3;

	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [7:0] ChQuestion = 8'h3F;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChNul = 8'h00;
	localparam logic [7:0] ChZero = 8'h30;
	localparam logic [7:0] ChNine = 8'h39;
	localparam logic [7:0] ChLowA = 8'h61;
	localparam logic [7:0] ChLowF = 8'h66;
	localparam logic [7:0] ChUpA = 8'h41;
	localparam logic [7:0] ChUpF = 8'h46;
	localparam logic [7:0] LowBias = 8'h57;
	localparam logic [7:0] UpBias = 8'h37;

	localparam logic [15:0] CapReset = 16'd256;

	localparam logic [1:0] PhCopy = 2'd0;
	localparam logic [1:0] PhPercent = 2'd1;
	localparam logic [1:0] PhDigit = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t [MaxRes-1:0] res;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic [QCntW-1:0] count;
	} q_stat_t;

endpackage

// ===== rtl/upd_front.sv =====
module upd_front (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic [7:0] in_char,
	input logic first,
	input logic cfg_write,
	input logic [15:0] out_capacity,
	output logic wr_en,
	output upd_pkg::q_entry_t wr_data
);

	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] held;
		logic [15:0] count;
		logic finished;
	} st_t;

	typedef struct packed {
		st_t st;
		upd_pkg::q_entry_t e;
	} work_t;

	st_t st_q;
	logic [15:0] cap_q;
	logic [15:0] limit;
	work_t w;
	logic [4:0] hv;
	logic [4:0] hh;

	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= upd_pkg::ChZero && c <= upd_pkg::ChNine) begin
			r = {1'b1, 4'(c - upd_pkg::ChZero)};
		end else if (c >= upd_pkg::ChLowA && c <= upd_pkg::ChLowF) begin
			r = {1'b1, 4'(c - upd_pkg::LowBias)};
		end else if (c >= upd_pkg::ChUpA && c <= upd_pkg::ChUpF) begin
			r = {1'b1, 4'(c - upd_pkg::UpBias)};
		end
		return r;
	endfunction

	function automatic work_t put(input work_t wi, input logic [7:0] d, input logic l);
		work_t r;
		r = wi;
		if (r.e.n != 2'd3) begin
			r.e.res[r.e.n] = '{data: d, last: l};
			r.e.n = r.e.n + 2'd1;
		end
		return r;
	endfunction

	function automatic work_t term(input work_t wi);
		work_t r;
		r = put(wi, upd_pkg::ChNul, 1'b1);
		r.st.finished = 1'b1;
		r.st.phase = upd_pkg::PhCopy;
		return r;
	endfunction

	function automatic work_t plain(input work_t wi, input logic [7:0] c,
			input logic [15:0] lim);
		work_t r;
		r = wi;
		if (!r.st.finished) begin
			if (c == upd_pkg::ChNul || c == upd_pkg::ChQuestion || c == upd_pkg::ChSpace) begin
				r = term(r);
			end else if (r.st.count >= lim) begin
				r = term(r);
			end else if (c == upd_pkg::ChPercent) begin
				r.st.phase = upd_pkg::PhPercent;
			end else begin
				r = put(r, c, 1'b0);
				r.st.count = r.st.count + 16'd1;
			end
		end
		return r;
	endfunction

	assign limit = (cap_q == 16'd0) ? 16'd0 : cap_q - 16'd1;
	assign hv = hex_of(in_char);
	assign hh = hex_of(st_q.held);

	always_comb begin
		w = '0;
		w.st = st_q;
		if (first) begin
			w.st = '{phase: upd_pkg::PhCopy, held: 8'd0, count: 16'd0, finished: 1'b0};
		end
		if (!w.st.finished) begin
			case (w.st.phase)
				upd_pkg::PhPercent: begin
					if (hv[4]) begin
						w.st.held = in_char;
						w.st.phase = upd_pkg::PhDigit;
					end else begin
						w.st.phase = upd_pkg::PhCopy;
						w = put(w, upd_pkg::ChPercent, 1'b0);
						w.st.count = w.st.count + 16'd1;
						w = plain(w, in_char, limit);
					end
				end
				upd_pkg::PhDigit: begin
					w.st.phase = upd_pkg::PhCopy;
					if (hv[4]) begin
						w = put(w, {hh[3:0], hv[3:0]}, 1'b0);
						w.st.count = w.st.count + 16'd1;
					end else begin
						w = put(w, upd_pkg::ChPercent, 1'b0);
						w.st.count = w.st.count + 16'd1;
						w = plain(w, w.st.held, limit);
						w = plain(w, in_char, limit);
					end
				end
				default: begin
					w.st.phase = upd_pkg::PhCopy;
					w = plain(w, in_char, limit);
				end
			endcase
		end
	end

	assign wr_en = take && (w.e.n != 2'd0);
	assign wr_data = w.e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: upd_pkg::PhCopy, held: 8'd0, count: 16'd0, finished: 1'b1};
			cap_q <= upd_pkg::CapReset;
		end else begin
			if (take) begin
				st_q <= w.st;
			end
			if (cfg_write) begin
				cap_q <= out_capacity;
			end
		end
	end

endmodule

// ===== rtl/upd_queue.sv =====
module upd_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input upd_pkg::q_entry_t wr_data,
	input logic rd_en,
	output upd_pkg::q_entry_t rd_data,
	output upd_pkg::q_stat_t stat
);

	upd_pkg::q_entry_t slot_q [upd_pkg::QDepth];
	logic [upd_pkg::QPtrW-1:0] wp_q;
	logic [upd_pkg::QPtrW-1:0] rp_q;
	logic [upd_pkg::QCntW-1:0] cnt_q;

	assign rd_data = slot_q[rp_q];
	assign stat.count = cnt_q;
	assign stat.empty = (cnt_q == '0);
	assign stat.full = (cnt_q == upd_pkg::QCntW'(upd_pkg::QDepth));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/upd_back.sv =====
module upd_back (
	input logic clk,
	input logic arst_n,
	input upd_pkg::q_entry_t rd_data,
	input upd_pkg::q_stat_t stat,
	output logic rd_en,
	input logic pop,
	output logic empty,
	output logic [7:0] out_byte,
	output logic last
);

	upd_pkg::q_entry_t wk_q;
	logic wk_valid_q;
	logic [1:0] idx_q;
	logic ov_q;
	logic [7:0] ob_q;
	logic ol_q;
	logic adv;
	logic take_res;
	logic wk_done;

	assign adv = !ov_q || pop;
	assign take_res = adv && wk_valid_q;
	assign wk_done = take_res && (idx_q == wk_q.n - 2'd1);
	assign rd_en = (!wk_valid_q || wk_done) && !stat.empty;

	assign empty = !ov_q;
	assign out_byte = ob_q;
	assign last = ol_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			wk_q <= rd_data;
		end
		if (take_res) begin
			ob_q <= wk_q.res[idx_q].data;
			ol_q <= wk_q.res[idx_q].last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wk_valid_q <= 1'b0;
			idx_q <= 2'd0;
			ov_q <= 1'b0;
		end else begin
			wk_valid_q <= rd_en || (wk_valid_q && !wk_done);
			ov_q <= take_res || (ov_q && !pop);
			if (rd_en) begin
				idx_q <= 2'd0;
			end else if (take_res) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ===== rtl/url_percent_decoder.sv =====
// A result passes through the queue, the working entry register and the output register.
// Throughput: one input transfer per cycle while the queue is not full and each byte
// yields at most one result; the result stage emits one result per cycle while the
// output is popped, so a byte with more results holds it longer. A four-entry queue
// between the decoder and the result stage absorbs such bursts. Reset (arst_n low,
// asynchronous) empties the queue, sets capacity to 256 and waits for a start byte.
module url_percent_decoder (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] in_char,
	input logic first,
	output logic empty,
	input logic pop,
	output logic [7:0] out_byte,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [15:0] out_capacity
);

	logic take;
	logic wr_en;
	logic rd_en;
	upd_pkg::q_entry_t wr_data;
	upd_pkg::q_entry_t rd_data;
	upd_pkg::q_stat_t qstat;

	assign full = qstat.full;
	assign take = push && !qstat.full;
	assign cfg_ready = 1'b1;

	upd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.in_char(in_char),
		.first(first),
		.cfg_write(cfg_valid && cfg_ready),
		.out_capacity(out_capacity),
		.wr_en(wr_en),
		.wr_data(wr_data)
	);

	upd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_data(rd_data),
		.stat(qstat)
	);

	upd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rd_data(rd_data),
		.stat(qstat),
		.rd_en(rd_en),
		.pop(pop),
		.empty(empty),
		.out_byte(out_byte),
		.last(last)
	);

	// A terminator always carries a zero byte.
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> (out_byte == 8'h00))
		else $error("terminator with nonzero byte");

	// The queue never holds more entries than it has slots.
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= upd_pkg::QCntW'(upd_pkg::QDepth))
		else $error("queue count out of range");

	// A write into a full queue would lose a transfer.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !qstat.full)
		else $error("queue overrun");

endmodule
